FILE: hdl/lcdw_pkg.sv
// ----------------------------------------------------------------------------
// lcdw_pkg
// Shared types and constants for the palette pixel to 9-bit serial LCD writer.
// ----------------------------------------------------------------------------
package lcdw_pkg;

  // Default configuration
  localparam int unsigned PaletteEntriesDef = 224;
  localparam int unsigned QueueDepthDef     = 2;
  localparam logic [7:0]  IndexBaseReset    = 8'd32;

  // Frame layout: D/C bit in slot 0, data bits in slots 1..8
  localparam logic [3:0]  SlotDc            = 4'd0;
  localparam logic [3:0]  SlotFirstData     = 4'd1;
  localparam logic [3:0]  SlotLast          = 4'd8;

  // Request codes
  typedef enum logic [1:0] {
    REQ_CMD   = 2'd0,
    REQ_DATA  = 2'd1,
    REQ_LOAD  = 2'd2,
    REQ_PIXEL = 2'd3
  } lcdw_req_t;

  // One job handed from the front end to the serializer
  typedef struct packed {
    logic        err;    // bad pixel index: one error result, no bits
    logic        dc;     // level of the D/C bit of the first frame
    logic        two;    // a second data frame follows the first
    logic [15:0] data;   // first frame byte in [15:8], second in [7:0]
  } lcdw_job_t;

  // Palette entry from an RGB888 color
  function automatic logic [15:0] to_rgb565(input logic [7:0] r,
                                            input logic [7:0] g,
                                            input logic [7:0] b);
    to_rgb565 = {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

FILE: hdl/palette_pixel_to_spi9_lcd_writer_core.sv
// ----------------------------------------------------------------------------
// palette_pixel_to_spi9_lcd_writer_core
// Palette pixel to three-wire 9-bit serial LCD writer, top level.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue (in_push / in_full): command, data, palette load or pixel
//   requests. A command or data request gives one 9-bit frame, a pixel
//   gives two data frames (RGB565, high byte first), a palette load gives
//   no result, and a pixel index outside the palette gives one result with
//   out_index_error set and no bits.
//   Result queue (out_empty / out_pop): one result per bit period, D/C bit
//   first, then eight data bits MSB first; out_last marks the final result
//   of a request.
//   Throughput: the serializer emits one result per clock while the
//   receiver keeps popping; palette loads take an input slot but give no
//   result. From accept, a request passes through the front-end stage
//   register, the job queue and the output register to its first result.
//   When out_pop stays low the last result holds, the job queue fills and
//   in_full rises; nothing is dropped. Requests keep being accepted while
//   earlier ones are serialized, as long as the queue has room.
//   Reset clears all control state and sets index_base to 32. The palette
//   memory is not cleared: write an entry before a pixel uses it.
//   cfg_wr_en / cfg_wr_data write index_base; write it only while idle.
// ----------------------------------------------------------------------------
module palette_pixel_to_spi9_lcd_writer_core #(
  parameter int unsigned PALETTE_ENTRIES = lcdw_pkg::PaletteEntriesDef,
  parameter int unsigned QUEUE_DEPTH     = lcdw_pkg::QueueDepthDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_push,
  output logic       in_full,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_byte_value,
  input  logic [7:0] in_palette_slot,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_pixel_index,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_serial_bit,
  output logic [3:0] out_bit_slot,
  output logic       out_frame_end,
  output logic       out_index_error,
  output logic       out_last
);
  import lcdw_pkg::*;

  lcdw_job_t q_wr_data;
  lcdw_job_t q_rd_data;
  logic      q_push, q_full;
  logic      q_pop,  q_empty;

  // Front end: decode, palette, index check
  lcdw_front #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_req_type     (in_req_type),
    .in_byte_value   (in_byte_value),
    .in_palette_slot (in_palette_slot),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_pixel_index  (in_pixel_index),
    .job_push        (q_push),
    .job_full        (q_full),
    .job_data        (q_wr_data)
  );

  // Job queue
  lcdw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .full    (q_full),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd_data)
  );

  // Serializer
  lcdw_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_empty       (q_empty),
    .job_pop         (q_pop),
    .job_data        (q_rd_data),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_serial_bit  (out_serial_bit),
    .out_bit_slot    (out_bit_slot),
    .out_frame_end   (out_frame_end),
    .out_index_error (out_index_error),
    .out_last        (out_last)
  );

endmodule

FILE: hdl/lcdw_front.sv
// ----------------------------------------------------------------------------
// lcdw_front
// Accepts requests, holds the base register and the palette memory, turns
// each request into a serializer job. Palette loads end here.
// ----------------------------------------------------------------------------
module lcdw_front #(
  parameter int unsigned PALETTE_ENTRIES = lcdw_pkg::PaletteEntriesDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                in_push,
  output logic                in_full,
  input  logic [1:0]          in_req_type,
  input  logic [7:0]          in_byte_value,
  input  logic [7:0]          in_palette_slot,
  input  logic [7:0]          in_red,
  input  logic [7:0]          in_green,
  input  logic [7:0]          in_blue,
  input  logic [7:0]          in_pixel_index,
  output logic                job_push,
  input  logic                job_full,
  output lcdw_pkg::lcdw_job_t job_data
);
  import lcdw_pkg::*;

  localparam int unsigned AddrW   = $clog2(PALETTE_ENTRIES);
  localparam logic [8:0]  Entries = 9'(PALETTE_ENTRIES);

  logic [7:0]  index_base_r;
  logic [15:0] pal_mem [PALETTE_ENTRIES];
  logic [15:0] rd_data_r;

  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_pix_r;
  logic        s1_err_r;
  logic        s1_dc_r;
  logic [7:0]  s1_byte_r;

  logic        accept;
  logic        s1_move;
  logic [8:0]  diff;
  logic        idx_err;
  logic        slot_ok;
  logic        is_load;
  logic        is_pixel;
  logic        is_data;

  // Base register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_base_r <= IndexBaseReset;
    end else if (cfg_wr_en) begin
      index_base_r <= cfg_wr_data;
    end
  end

  // Request decode
  always_comb begin
    is_load  = 1'b0;
    is_pixel = 1'b0;
    is_data  = 1'b0;
    unique case (lcdw_req_t'(in_req_type))
      REQ_CMD:   is_data  = 1'b0;
      REQ_DATA:  is_data  = 1'b1;
      REQ_LOAD:  is_load  = 1'b1;
      REQ_PIXEL: is_pixel = 1'b1;
      default:   is_load  = 1'b0;
    endcase
  end

  // Index check: borrow or past the end of the palette
  assign diff    = {1'b0, in_pixel_index} - {1'b0, index_base_r};
  assign idx_err = diff[8] || (diff >= Entries);
  assign slot_ok = ({1'b0, in_palette_slot} < Entries);

  // Handshake: stage 1 drains into the job queue
  assign s1_move = !s1_valid_r || !job_full;
  assign in_full = !s1_move;
  assign accept  = in_push && s1_move;

  // Palette memory: at most one write or one registered read per accepted request
  always_ff @(posedge clk) begin
    if (accept && is_load && slot_ok) begin
      pal_mem[in_palette_slot[AddrW-1:0]] <= to_rgb565(in_red, in_green, in_blue);
    end
    if (accept && is_pixel) begin
      rd_data_r <= pal_mem[diff[AddrW-1:0]];
    end
  end

  // Stage 1 control
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_move) begin
      s1_valid_nxt = accept && !is_load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= is_pixel;
      s1_err_r  <= is_pixel && idx_err;
      s1_dc_r   <= is_data || is_pixel;
      s1_byte_r <= in_byte_value;
    end
  end

  // Job to the queue
  assign job_push      = s1_valid_r && !job_full;
  assign job_data.err  = s1_err_r;
  assign job_data.dc   = s1_dc_r;
  assign job_data.two  = s1_pix_r;
  assign job_data.data = s1_pix_r ? rd_data_r : {s1_byte_r, 8'h00};

endmodule

FILE: hdl/lcdw_queue.sv
// ----------------------------------------------------------------------------
// lcdw_queue
// Small register queue of serializer jobs between front end and serializer.
// ----------------------------------------------------------------------------
module lcdw_queue #(
  parameter int unsigned DEPTH = lcdw_pkg::QueueDepthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  lcdw_pkg::lcdw_job_t wr_data,
  input  logic                pop,
  output logic                empty,
  output lcdw_pkg::lcdw_job_t rd_data
);
  import lcdw_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntMax = CntW'(DEPTH);

  lcdw_job_t       slots_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r,  count_nxt;
  logic            do_push, do_pop;

  assign full    = (count_r == CntMax);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrMax) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrMax) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: hdl/lcdw_back.sv
// ----------------------------------------------------------------------------
// lcdw_back
// Serializer: turns jobs into one result per bit period, with an output
// register that holds the oldest result until it is popped.
// ----------------------------------------------------------------------------
module lcdw_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_empty,
  output logic                job_pop,
  input  lcdw_pkg::lcdw_job_t job_data,
  output logic                out_empty,
  input  logic                out_pop,
  output logic                out_serial_bit,
  output logic [3:0]          out_bit_slot,
  output logic                out_frame_end,
  output logic                out_index_error,
  output logic                out_last
);
  import lcdw_pkg::*;

  // Serializer state
  logic        busy_r,  busy_nxt;
  logic [3:0]  slot_r,  slot_nxt;
  logic        two_r,   two_nxt;
  logic        dc_r,    dc_nxt;
  logic [15:0] shift_r, shift_nxt;

  // Output register
  logic        valid_r, valid_nxt;
  logic        bit_r,   bit_nxt;
  logic [3:0]  oslot_r, oslot_nxt;
  logic        fend_r,  fend_nxt;
  logic        err_r,   err_nxt;
  logic        last_r,  last_nxt;

  logic        advance;

  assign advance = !valid_r || out_pop;
  assign job_pop = advance && !busy_r && !job_empty;

  // Next result
  always_comb begin
    busy_nxt  = busy_r;
    slot_nxt  = slot_r;
    two_nxt   = two_r;
    dc_nxt    = dc_r;
    shift_nxt = shift_r;
    valid_nxt = valid_r;
    bit_nxt   = bit_r;
    oslot_nxt = oslot_r;
    fend_nxt  = fend_r;
    err_nxt   = err_r;
    last_nxt  = last_r;
    if (advance) begin
      if (busy_r) begin
        // one bit of the current frame
        valid_nxt = 1'b1;
        err_nxt   = 1'b0;
        oslot_nxt = slot_r;
        fend_nxt  = (slot_r == SlotLast);
        last_nxt  = (slot_r == SlotLast) && !two_r;
        if (slot_r == SlotDc) begin
          bit_nxt = dc_r;
        end else begin
          bit_nxt   = shift_r[15];
          shift_nxt = {shift_r[14:0], 1'b0};
        end
        if (slot_r == SlotLast) begin
          slot_nxt = SlotDc;
          two_nxt  = 1'b0;
          busy_nxt = two_r;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end else if (!job_empty) begin
        valid_nxt = 1'b1;
        if (job_data.err) begin
          // error result, no bits
          bit_nxt   = 1'b0;
          oslot_nxt = SlotDc;
          fend_nxt  = 1'b0;
          err_nxt   = 1'b1;
          last_nxt  = 1'b1;
        end else begin
          // D/C bit goes out while the job loads
          bit_nxt   = job_data.dc;
          oslot_nxt = SlotDc;
          fend_nxt  = 1'b0;
          err_nxt   = 1'b0;
          last_nxt  = 1'b0;
          busy_nxt  = 1'b1;
          slot_nxt  = SlotFirstData;
          two_nxt   = job_data.two;
          dc_nxt    = job_data.dc;
          shift_nxt = job_data.data;
        end
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      slot_r  <= SlotDc;
      two_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      slot_r  <= slot_nxt;
      two_r   <= two_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    dc_r    <= dc_nxt;
    shift_r <= shift_nxt;
    bit_r   <= bit_nxt;
    oslot_r <= oslot_nxt;
    fend_r  <= fend_nxt;
    err_r   <= err_nxt;
    last_r  <= last_nxt;
  end

  assign out_empty       = !valid_r;
  assign out_serial_bit  = bit_r;
  assign out_bit_slot    = oslot_r;
  assign out_frame_end   = fend_r;
  assign out_index_error = err_r;
  assign out_last        = last_r;

endmodule

FILE: dv/tb_palette_pixel_to_spi9_lcd_writer_core.sv
// ----------------------------------------------------------------------------
// tb_palette_pixel_to_spi9_lcd_writer_core
// Self-checking bench for the palette pixel to 9-bit serial LCD writer.
// ----------------------------------------------------------------------------
// A burst-driven sender feeds command, data, palette load and pixel requests.
// A stalling receiver drains the bit results. Every accepted request goes
// through a local palette/serializer predictor. Each popped transaction is
// checked field by field against the oldest predicted bit. Phases are split
// by index_base writes made while the block is idle. One phase holds the
// receiver off long enough to back the block up to its input.
// ----------------------------------------------------------------------------
module tb_palette_pixel_to_spi9_lcd_writer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lcdw_pkg::*;

  localparam int unsigned Entries      = PaletteEntriesDef;
  localparam int          HalfPeriod   = 10;
  localparam int          ResetCycles  = 12;
  localparam int          SettleCycles = 8;
  localparam int          HoldCycles   = 400;
  localparam int          CycleLimit   = 200000;

  // One request as offered on the input ports
  typedef struct {
    lcdw_req_t  kind;
    logic [7:0] byte_value;
    logic [7:0] slot;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] pixel;
  } lcd_req_t;

  // One bit result on the output ports
  typedef struct packed {
    logic       sbit;
    logic [3:0] slot;
    logic       fend;
    logic       ierr;
    logic       lst;
  } lcd_bit_t;

  // Receiver pop patterns
  typedef enum int {
    POP_ALWAYS,
    POP_RANDOM,
    POP_SPARSE,
    POP_ALTERNATE
  } pop_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = '0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [1:0] in_req_type = '0;
  logic [7:0] in_byte_value = '0;
  logic [7:0] in_palette_slot = '0;
  logic [7:0] in_red = '0;
  logic [7:0] in_green = '0;
  logic [7:0] in_blue = '0;
  logic [7:0] in_pixel_index = '0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic       out_serial_bit;
  logic [3:0] out_bit_slot;
  logic       out_frame_end;
  logic       out_index_error;
  logic       out_last;

  lcd_req_t   pend_q[$];          // requests not yet accepted
  lcd_bit_t   frame_bits_q[$];    // predicted bits not yet popped
  logic [15:0] pred_palette[0:255];
  logic [7:0] pred_base = IndexBaseReset;

  // Stimulus-side view: which slots hold a color, and the current base
  bit         stim_written[0:255];
  int         stim_base = int'(IndexBaseReset);

  int         err_cnt = 0;
  int         cycle_cnt = 0;
  bit         steady_send = 1'b0;
  int         hold_reqs = 0;

  palette_pixel_to_spi9_lcd_writer_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_req_type     (in_req_type),
    .in_byte_value   (in_byte_value),
    .in_palette_slot (in_palette_slot),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_pixel_index  (in_pixel_index),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_serial_bit  (out_serial_bit),
    .out_bit_slot    (out_bit_slot),
    .out_frame_end   (out_frame_end),
    .out_index_error (out_index_error),
    .out_last        (out_last)
  );

  // Clock
  always begin
    clk = 1'b0;
    #(HalfPeriod);
    clk = 1'b1;
    #(HalfPeriod);
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // D/C bit then eight data bits, MSB first
  function automatic void push_frame(logic dc, logic [7:0] val, logic fin);
    lcd_bit_t   b;
    logic [8:0] word;
    word = {dc, val};
    for (int i = 0; i <= 8; i++) begin
      b.sbit = word[8 - i];
      b.slot = 4'(i);
      b.fend = (b.slot == SlotLast);
      b.ierr = 1'b0;
      b.lst  = fin && b.fend;
      frame_bits_q.push_back(b);
    end
  endfunction

  function automatic void serialize_request(lcd_req_t r);
    int          idx;
    logic [15:0] color;
    lcd_bit_t    bad;
    case (r.kind)
      REQ_CMD: begin
        push_frame(1'b0, r.byte_value, 1'b1);
      end
      REQ_DATA: begin
        push_frame(1'b1, r.byte_value, 1'b1);
      end
      REQ_LOAD: begin
        // slots past the palette are dropped
        if (r.slot < Entries) begin
          pred_palette[r.slot] = {r.red[7:3], r.green[7:2], r.blue[7:3]};
        end
      end
      default: begin
        idx = int'(r.pixel) - int'(pred_base);
        if (idx < 0 || idx >= int'(Entries)) begin
          bad = '0;
          bad.ierr = 1'b1;
          bad.lst = 1'b1;
          frame_bits_q.push_back(bad);
        end else begin
          color = pred_palette[idx];
          push_frame(1'b1, color[15:8], 1'b0);
          push_frame(1'b1, color[7:0], 1'b1);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Unused fields carry random junk so every input bit toggles
  function automatic lcd_req_t rand_req(lcdw_req_t kind);
    lcd_req_t r;
    r.kind       = kind;
    r.byte_value = 8'($urandom_range(0, 255));
    r.slot       = 8'($urandom_range(0, 255));
    r.red        = 8'($urandom_range(0, 255));
    r.green      = 8'($urandom_range(0, 255));
    r.blue       = 8'($urandom_range(0, 255));
    r.pixel      = 8'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic void add_byte(lcdw_req_t kind, logic [7:0] val);
    lcd_req_t r;
    r = rand_req(kind);
    r.byte_value = val;
    pend_q.push_back(r);
  endfunction

  function automatic void add_load(logic [7:0] slot, logic [7:0] red, logic [7:0] green,
                                   logic [7:0] blue);
    lcd_req_t r;
    r = rand_req(REQ_LOAD);
    r.slot  = slot;
    r.red   = red;
    r.green = green;
    r.blue  = blue;
    if (slot < Entries) begin
      stim_written[slot] = 1'b1;
    end
    pend_q.push_back(r);
  endfunction

  function automatic void add_pixel(logic [7:0] pix);
    lcd_req_t r;
    r = rand_req(REQ_PIXEL);
    r.pixel = pix;
    pend_q.push_back(r);
  endfunction

  // Mostly a written entry; otherwise an index outside the palette.
  // Never an in-range entry that holds no color yet.
  function automatic logic [7:0] pick_pixel();
    int cand[$];
    int pos;
    for (int i = 0; i < int'(Entries); i++) begin
      if (stim_written[i] && i + stim_base <= 255) begin
        cand.push_back(i);
      end
    end
    if (cand.size() > 0 && $urandom_range(0, 4) != 0) begin
      pos = $urandom_range(0, cand.size() - 1);
      return 8'(cand[pos] + stim_base);
    end
    if (stim_base > 0 && (stim_base + int'(Entries) > 255 || $urandom_range(0, 1) == 0)) begin
      return 8'($urandom_range(0, stim_base - 1));
    end
    return 8'($urandom_range(stim_base + int'(Entries), 255));
  endfunction

  function automatic void add_random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      add_byte(REQ_CMD, 8'($urandom_range(0, 255)));
    end else if (pick < 36) begin
      add_byte(REQ_DATA, 8'($urandom_range(0, 255)));
    end else if (pick < 60) begin
      add_load(($urandom_range(0, 9) == 0) ? 8'($urandom_range(Entries, 255))
                                            : 8'($urandom_range(0, Entries - 1)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
    end else begin
      add_pixel(pick_pixel());
    end
  endfunction

  // Sender drained, every result back, then let the pipe settle
  task automatic wait_idle();
    while (pend_q.size() != 0 || frame_bits_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic cfg_write(logic [7:0] val);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    pred_base = val;
    stim_base = int'(val);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts with random gaps, fed from pend_q
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n || pend_q.size() == 0) begin
      in_push <= 1'b0;
    end else if (gap_left > 0 && !steady_send) begin
      in_push <= 1'b0;
      gap_left--;
    end else begin
      in_push         <= 1'b1;
      in_req_type     <= pend_q[0].kind;
      in_byte_value   <= pend_q[0].byte_value;
      in_palette_slot <= pend_q[0].slot;
      in_red          <= pend_q[0].red;
      in_green        <= pend_q[0].green;
      in_blue         <= pend_q[0].blue;
      in_pixel_index  <= pend_q[0].pixel;
      if (burst_left > 0) begin
        burst_left--;
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: pop pattern switches at random; long hold on request
  // ---------------------------------------------------------------------------
  pop_mode_t pop_mode = POP_ALWAYS;
  int        mode_left = 0;
  int        hold_seen = 0;
  int        hold_left = 0;
  bit        alt_phase = 1'b0;

  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HoldCycles;
    end
    if (mode_left == 0) begin
      pop_mode = pop_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(16, 96);
    end else begin
      mode_left--;
    end
    alt_phase = !alt_phase;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      out_pop <= 1'b0;
      hold_left--;
    end else begin
      case (pop_mode)
        POP_ALWAYS:    out_pop <= 1'b1;
        POP_RANDOM:    out_pop <= 1'($urandom_range(0, 1));
        POP_SPARSE:    out_pop <= ($urandom_range(0, 5) == 0);
        default:       out_pop <= alt_phase;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on accept, then check the popped transaction
  // ---------------------------------------------------------------------------
  function automatic void check_field(string what, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  lcd_bit_t want_bit;

  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      serialize_request(pend_q.pop_front());
    end
    if (rst_n && out_pop && !out_empty) begin
      if (frame_bits_q.size() == 0) begin
        err_cnt++;
        $display({"%0t ns: unexpected result, expected none, ",
                  "actual bit=%0b slot=%0d end=%0b err=%0b last=%0b"},
                 $time, out_serial_bit, out_bit_slot, out_frame_end, out_index_error, out_last);
      end else begin
        want_bit = frame_bits_q.pop_front();
        check_field("serial_bit", 4'(want_bit.sbit), 4'(out_serial_bit));
        check_field("bit_slot", want_bit.slot, out_bit_slot);
        check_field("frame_end", 4'(want_bit.fend), 4'(out_frame_end));
        check_field("index_error", 4'(want_bit.ierr), 4'(out_index_error));
        check_field("last", 4'(want_bit.lst), 4'(out_last));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;

    // reset base: command/data extremes, loads incl. dropped slots, pixels
    add_byte(REQ_CMD, 8'h00);
    add_byte(REQ_CMD, 8'hFF);
    add_byte(REQ_DATA, 8'hA5);
    add_byte(REQ_DATA, 8'h5A);
    add_load(8'd0, 8'hFF, 8'hFF, 8'hFF);
    add_load(8'd223, 8'h80, 8'h40, 8'h08);
    add_load(8'd1, 8'h07, 8'h03, 8'h07);
    add_load(8'd224, 8'h11, 8'h22, 8'h33);
    add_load(8'd255, 8'hFF, 8'h00, 8'hFF);
    add_pixel(8'd32);
    add_pixel(8'd255);
    add_pixel(8'd33);
    add_pixel(8'd31);
    add_pixel(8'd0);
    wait_idle();

    // base 0: both ends of the palette and just past it
    cfg_write(8'd0);
    add_pixel(8'd0);
    add_pixel(8'd223);
    add_pixel(8'd224);
    add_pixel(8'd255);
    add_load(8'd2, 8'h12, 8'h34, 8'h56);
    add_pixel(8'd2);
    wait_idle();

    // base 255: only index 255 lands in the palette
    cfg_write(8'd255);
    add_pixel(8'd255);
    add_pixel(8'd254);
    add_pixel(8'd0);
    wait_idle();

    // backpressure: receiver held off, sender keeps offering
    cfg_write(8'd0);
    @(posedge clk);
    steady_send = 1'b1;
    hold_reqs++;
    repeat (16) add_random_item();
    wait_idle();
    @(posedge clk);
    steady_send = 1'b0;

    // random phases, each with its own base
    for (int ph = 0; ph < 4; ph++) begin
      cfg_write(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 48))
                                            : 8'($urandom_range(0, 255)));
      repeat (20) add_random_item();
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/lcdw_pkg.sv
hdl/lcdw_front.sv
hdl/lcdw_queue.sv
hdl/lcdw_back.sv
hdl/palette_pixel_to_spi9_lcd_writer_core.sv
dv/tb_palette_pixel_to_spi9_lcd_writer_core.sv
